/* src/byte_range_lock_table_assert.svh */
// Assertion helpers used by the lock table RTL.
`ifndef BYTE_RANGE_LOCK_TABLE_ASSERT_SVH
`define BYTE_RANGE_LOCK_TABLE_ASSERT_SVH

// Same-cycle implication.
`define BRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lock table check failed");

// Next-cycle implication.
`define BRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lock table check failed");

`endif

/* src/brl_pkg.sv */
package brl_pkg;

  localparam logic [2:0] CMD_LOCK   = 3'd0;
  localparam logic [2:0] CMD_UNLOCK = 3'd1;
  localparam logic [2:0] CMD_RMPEND = 3'd2;
  localparam logic [2:0] CMD_TEST   = 3'd3;
  localparam logic [2:0] CMD_CLOSE  = 3'd4;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_PREAD  = 2'd2;
  localparam logic [1:0] KIND_PWRITE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_GRANT = 3'd1;
  localparam logic [2:0] ST_CONFLICT  = 3'd2;
  localparam logic [2:0] ST_NOT_LOCK  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [31:0] node_id;
    logic [15:0] conn_id;
    logic [15:0] smbpid;
    logic [15:0] notify_tag;
    logic [1:0]  lock_kind;
    logic [15:0] handle_id;
    logic [15:0] file_id;
    logic [63:0] range_start;
    logic [63:0] range_size;
  } entry_t;

  typedef struct packed {
    logic shift;      // take neighbor's entry
    logic load_head;  // take entry leaving the head
    logic load_new;   // append new lock
  } cell_ctl_t;

  typedef struct packed {
    logic conflict;
    logic unl_w;
    logic unl_n;
    logic pend;
    logic close;
  } match_t;

endpackage

/* src/brl_cell.sv */
module brl_cell (
  input  logic               clk,
  input  brl_pkg::cell_ctl_t ctl,
  input  brl_pkg::entry_t    nbr,
  input  brl_pkg::entry_t    head,
  input  brl_pkg::entry_t    fresh,
  output brl_pkg::entry_t    q
);
  import brl_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      q_r <= fresh;
    end else if (ctl.load_head) begin
      q_r <= head;
    end else if (ctl.shift) begin
      q_r <= nbr;
    end
  end

  assign q = q_r;

endmodule

/* src/brl_match.sv */
module brl_match (
  input  brl_pkg::entry_t ent,
  input  brl_pkg::entry_t req,
  input  logic            relaxed,
  output brl_pkg::match_t m
);
  import brl_pkg::*;

  logic        file_eq, owner_eq, handle_eq, same, exempt, overlap;
  logic [63:0] end_e, end_r;

  always_comb begin
    file_eq   = ent.file_id == req.file_id;
    owner_eq  = ent.node_id == req.node_id && ent.conn_id == req.conn_id &&
                ent.smbpid == req.smbpid;
    handle_eq = ent.handle_id == req.handle_id;
    same      = owner_eq && handle_eq;
    end_e     = ent.range_start + ent.range_size;
    end_r     = req.range_start + req.range_size;
    overlap   = (ent.range_size != 64'd0 && ent.range_start == req.range_start &&
                 ent.range_size == req.range_size) ||
                !(ent.range_start >= end_r || req.range_start >= end_e);
    // pending never conflicts, read/read never conflicts
    exempt    = ent.lock_kind[1] || req.lock_kind[1] ||
                (ent.lock_kind == KIND_READ && req.lock_kind == KIND_READ) ||
                (same && (req.lock_kind == KIND_READ ||
                          (relaxed && ent.lock_kind == KIND_WRITE)));
    m.conflict = file_eq && !exempt && overlap;
    m.unl_w    = file_eq && same && ent.range_start == req.range_start &&
                 ent.range_size == req.range_size && ent.lock_kind == KIND_WRITE;
    m.unl_n    = file_eq && same && ent.range_start == req.range_start &&
                 ent.range_size == req.range_size && !ent.lock_kind[1];
    m.pend     = file_eq && ent.lock_kind[1] && ent.notify_tag == req.notify_tag &&
                 ent.node_id == req.node_id;
    m.close    = file_eq && ent.node_id == req.node_id &&
                 ent.conn_id == req.conn_id && handle_eq;
  end

endmodule

/* src/byte_range_lock_table.sv */
// Byte-range lock table.
// Requests enter on the in_ stream (in_tuser = command, in_tdata = lock
// fields); every request returns exactly one result on the out_ stream
// (status and the table's entry count after the request).
// Entries sit in a chain of cells. A request rotates the live entries
// once through the head, one entry per cycle, checking each there (an
// unlock that finds its entry rotates twice); dropped entries are not
// re-queued, so the survivors come back compacted in their old order.
// out_tvalid rises once the rotation over the held entries is done (for
// an unlock that finds its entry, after both) and S_FIN registers the
// result. One request is in flight at a time; the next can be taken the
// cycle after the result is registered.
// A stalled receiver holds the result; a request that finishes meanwhile
// waits in its last step and in_tready stays low until the result moves.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// entry storage itself is not cleared.
module byte_range_lock_table #(
  parameter int LOCK_ENTRIES = 64,
  localparam int CW = $clog2(LOCK_ENTRIES + 1),
  localparam int OW = ((3 + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // [15:0] file_id, [47:16] node_id, [63:48] conn_id, [79:64] smbpid,
  // [95:80] handle_id, [159:96] range_start, [223:160] range_size,
  // [225:224] lock_kind, [241:226] notify_tag, [247:242] zero
  input  logic [247:0]   in_tdata,
  // [2:0] cmd
  input  logic [2:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  // [2:0] status, [CW+2:3] lock_count, rest zero
  output logic [OW-1:0]  out_tdata
);
  import brl_pkg::*;

  `include "byte_range_lock_table_assert.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SCAN2 = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;
  localparam logic [CW-1:0] FULL = CW'(LOCK_ENTRIES);

  logic [1:0]    state_r;
  entry_t        req_r;
  logic [2:0]    cmd_r;
  logic [CW-1:0] k_r, cnt_r, cnt0_r, iw_r, in_r, tgt_r;
  logic          hit_r, fw_r, fn_r, done_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [CW-1:0] out_cnt_r;

  entry_t    cell_q [LOCK_ENTRIES];
  cell_ctl_t ctl [LOCK_ENTRIES];
  entry_t    in_ent;
  match_t    m;
  logic      scanning, drop, append, last;
  logic      fw_nxt, fn_nxt;
  logic [CW-1:0] iw_nxt, in_nxt, cnt_m1;
  logic [2:0]    status_nxt;

  assign in_ent.file_id     = in_tdata[15:0];
  assign in_ent.node_id     = in_tdata[47:16];
  assign in_ent.conn_id     = in_tdata[63:48];
  assign in_ent.smbpid      = in_tdata[79:64];
  assign in_ent.handle_id   = in_tdata[95:80];
  assign in_ent.range_start = in_tdata[159:96];
  assign in_ent.range_size  = in_tdata[223:160];
  assign in_ent.lock_kind   = in_tdata[225:224];
  assign in_ent.notify_tag  = in_tdata[241:226];

  brl_match u_match (
    .ent     (cell_q[0]),
    .req     (req_r),
    .relaxed (cmd_r == CMD_TEST),
    .m       (m)
  );

  always_comb begin
    scanning = state_r == S_SCAN || state_r == S_SCAN2;
    cnt_m1   = cnt_r - CW'(1);
    last     = k_r == cnt0_r - CW'(1);
    if (state_r == S_SCAN2) begin
      drop = k_r == tgt_r;
    end else begin
      drop = state_r == S_SCAN &&
             ((cmd_r == CMD_RMPEND && m.pend && !done_r) ||
              (cmd_r == CMD_CLOSE && m.close));
    end
    // a pending lock is stored too
    append = state_r == S_FIN && cmd_r == CMD_LOCK && !hit_r && cnt_r != FULL;
    fw_nxt = fw_r || (cmd_r == CMD_UNLOCK && m.unl_w);
    fn_nxt = fn_r || (cmd_r == CMD_UNLOCK && m.unl_n);
    iw_nxt = fw_r ? iw_r : k_r;
    in_nxt = fn_r ? in_r : k_r;
    unique case (cmd_r)
      CMD_LOCK:   status_nxt = hit_r ? ST_NOT_GRANT : (cnt_r == FULL) ? ST_FULL :
                               req_r.lock_kind[1] ? ST_NOT_GRANT : ST_OK;
      CMD_TEST:   status_nxt = hit_r ? ST_CONFLICT : ST_OK;
      CMD_UNLOCK: status_nxt = (fw_r || fn_r) ? ST_OK : ST_NOT_LOCK;
      CMD_RMPEND: status_nxt = done_r ? ST_OK : ST_NOT_LOCK;
      default:    status_nxt = ST_OK;
    endcase
  end

  for (genvar i = 0; i < LOCK_ENTRIES; i++) begin : g_cell
    always_comb begin
      ctl[i].shift     = scanning && CW'(i) < cnt_m1;
      ctl[i].load_head = scanning && !drop && CW'(i) == cnt_m1;
      ctl[i].load_new  = append && CW'(i) == cnt_r;
    end
    brl_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[i]),
      .nbr   (cell_q[(i + 1 < LOCK_ENTRIES) ? i + 1 : i]),
      .head  (cell_q[0]),
      .fresh (req_r),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            req_r   <= in_ent;
            cmd_r   <= in_tuser;
            k_r     <= '0;
            cnt0_r  <= cnt_r;
            hit_r   <= 1'b0;
            fw_r    <= 1'b0;
            fn_r    <= 1'b0;
            done_r  <= 1'b0;
            state_r <= (cnt_r == '0) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          k_r <= k_r + CW'(1);
          if ((cmd_r == CMD_LOCK || cmd_r == CMD_TEST) && m.conflict) begin
            hit_r <= 1'b1;
          end
          fw_r <= fw_nxt;
          fn_r <= fn_nxt;
          iw_r <= iw_nxt;
          in_r <= in_nxt;
          if (drop) begin
            done_r <= 1'b1;
            cnt_r  <= cnt_m1;
          end
          if (last) begin
            if (fw_nxt || fn_nxt) begin
              tgt_r   <= fw_nxt ? iw_nxt : in_nxt;
              k_r     <= '0;
              state_r <= S_SCAN2;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SCAN2: begin
          k_r <= k_r + CW'(1);
          if (drop) begin
            cnt_r <= cnt_m1;
          end
          if (last) begin
            state_r <= S_FIN;
          end
        end
        default: begin
          // wait here while the previous result is still held
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_nxt;
            out_cnt_r    <= append ? cnt_r + CW'(1) : cnt_r;
            cnt_r        <= append ? cnt_r + CW'(1) : cnt_r;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_cnt_r, out_status_r});

  `BRL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= FULL)
  `BRL_ASSERT_NEXT(a_cnt_grows_at_fin, state_r != S_FIN, cnt_r <= $past(cnt_r))
  `BRL_ASSERT_NEXT(a_fin_gives_result, state_r == S_FIN && (!out_valid_r || out_tready), out_tvalid && state_r == S_IDLE)

endmodule
